>>> sv/reorder_buffer_with_retire_map_top_defines.svh
// Assertion macros shared by the reorder buffer RTL.
`ifndef REORDER_BUFFER_WITH_RETIRE_MAP_TOP_DEFINES_SVH
`define REORDER_BUFFER_WITH_RETIRE_MAP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RBRM_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("reorder buffer check failed");
`define RBRM_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("reorder buffer check failed");
`else
`define RBRM_ASSERT_SAME(lbl, pre, post)
`define RBRM_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

>>> sv/rbrm_pkg.sv
// Package with the types and constants of the reorder buffer.
`timescale 1ns / 1ps
package rbrm_pkg;

	localparam int DEF_ROB_DEPTH = 16;
	localparam int DEF_ARCH_REGS = 16;
	localparam int DEF_PHYS_REGS = 32;

	localparam int SLOT_W  = 4;
	localparam int ARCH_W  = 4;
	localparam int PHYS_W  = 5;
	localparam int COUNT_W = 32;

	typedef enum logic {
		REQ_ALLOC  = 1'b0,
		REQ_RETIRE = 1'b1
	} req_type_t;

	typedef struct packed {
		logic              req_type;
		logic [ARCH_W-1:0] dest_arch_reg;
		logic [PHYS_W-1:0] dest_phys_reg;
		logic              has_dest;
		logic              entry_done;
		logic              is_halt;
	} req_item_t;

	typedef struct packed {
		logic [ARCH_W-1:0] arch;
		logic [PHYS_W-1:0] phys;
		logic              has_dest;
		logic              done;
		logic              halt;
	} rob_entry_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  rob_slot;
		logic               accepted;
		logic               retired;
		logic               freed_valid;
		logic [COUNT_W-1:0] commit_count;
		logic               rob_full;
		logic               halt_retired;
	} rsp_item_t;

	typedef struct packed {
		logic              lookup;
		logic              commit;
		logic [ARCH_W-1:0] arch;
		logic [PHYS_W-1:0] phys;
	} map_req_t;

endpackage

>>> sv/rbrm_in_if.sv
// Request channel interface of the reorder buffer.
`timescale 1ns / 1ps
interface rbrm_in_if;
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [rbrm_pkg::ARCH_W-1:0] dest_arch_reg;
	logic [rbrm_pkg::PHYS_W-1:0] dest_phys_reg;
	logic                       has_dest;
	logic                       entry_done;
	logic                       is_halt;

	modport source (
		output valid, req_type, dest_arch_reg, dest_phys_reg, has_dest, entry_done, is_halt,
		input  ready
	);
	modport sink (
		input  valid, req_type, dest_arch_reg, dest_phys_reg, has_dest, entry_done, is_halt,
		output ready
	);
endinterface

>>> sv/rbrm_out_if.sv
// Result channel interface of the reorder buffer.
`timescale 1ns / 1ps
interface rbrm_out_if;
	logic                        valid;
	logic                        ready;
	logic [rbrm_pkg::SLOT_W-1:0]  rob_slot;
	logic                        accepted;
	logic                        retired;
	logic                        freed_valid;
	logic [rbrm_pkg::PHYS_W-1:0]  freed_phys_reg;
	logic [rbrm_pkg::COUNT_W-1:0] commit_count;
	logic                        rob_full;
	logic                        halt_retired;

	modport source (
		output valid, rob_slot, accepted, retired, freed_valid, freed_phys_reg, commit_count,
		       rob_full, halt_retired,
		input  ready
	);
	modport sink (
		input  valid, rob_slot, accepted, retired, freed_valid, freed_phys_reg, commit_count,
		       rob_full, halt_retired,
		output ready
	);
endinterface

>>> sv/rbrm_retire_map.sv
// Retirement rename map: valid flags in flops and physical registers in a memory.
`timescale 1ns / 1ps
module rbrm_retire_map #(
	parameter int ARCH_REGS = rbrm_pkg::DEF_ARCH_REGS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rbrm_pkg::map_req_t          req,
	output logic                        prior_valid,
	output logic [rbrm_pkg::PHYS_W-1:0] prior_phys
);

	localparam int AW = (ARCH_REGS > 1) ? $clog2(ARCH_REGS) : 1;

	logic [ARCH_REGS-1:0]        map_valid_q;
	logic [rbrm_pkg::PHYS_W-1:0] phys_mem [ARCH_REGS];
	logic [AW-1:0]               idx;

	assign idx         = AW'(req.arch);
	assign prior_valid = map_valid_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_valid_q <= '0;
		end else if (req.commit) begin
			map_valid_q[idx] <= 1'b1;
		end
	end

	// The read returns the mapping from before a commit in the same cycle.
	always_ff @(posedge clk) begin
		if (req.commit) begin
			phys_mem[idx] <= req.phys;
		end
	end

	always_ff @(posedge clk) begin
		if (req.lookup) begin
			prior_phys <= phys_mem[idx];
		end
	end

endmodule

>>> sv/reorder_buffer_with_retire_map_top.sv
// Top level of the reorder buffer with retirement rename map.
// Each request item asks either to allocate an entry at the tail or to retire the entry at the head;
// one result item comes back for every request. A request is registered on acceptance,
// processed against the buffer and map state once the result stage is free, and its
// result is registered, so one request is taken in every cycle while the result side keeps
// up. The entry payload lives in a memory whose head entry is prefetched into a register,
// and the previous mapping of a retired register is read from the map memory into the
// result stage; neither holds up the flow of requests.
`timescale 1ns / 1ps
`include "reorder_buffer_with_retire_map_top_defines.svh"
module reorder_buffer_with_retire_map_top #(
	parameter int ROB_DEPTH = rbrm_pkg::DEF_ROB_DEPTH,
	parameter int ARCH_REGS = rbrm_pkg::DEF_ARCH_REGS,
	parameter int PHYS_REGS = rbrm_pkg::DEF_PHYS_REGS
) (
	input  logic      clk,
	input  logic      arst_n,
	rbrm_in_if.sink   req,
	rbrm_out_if.source rsp
);

	localparam int PW = (ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1;
	localparam logic [PW-1:0] LAST_SLOT = PW'(ROB_DEPTH - 1);

	logic                 valid_s1;
	rbrm_pkg::req_item_t  item_s1;
	logic                 valid_s2;
	rbrm_pkg::rsp_item_t  res_s2;

	logic [ROB_DEPTH-1:0] entry_valid_q;
	logic [ROB_DEPTH-1:0] valid_nxt;
	logic [PW-1:0]        head_q;
	logic [PW-1:0]        tail_q;
	logic [PW-1:0]        head_nxt;
	logic [PW-1:0]        tail_nxt;
	logic [rbrm_pkg::COUNT_W-1:0] commit_cnt_q;
	logic [rbrm_pkg::COUNT_W-1:0] cnt_nxt;

	rbrm_pkg::rob_entry_t payload_mem [ROB_DEPTH];
	rbrm_pkg::rob_entry_t head_pl_q;
	rbrm_pkg::rob_entry_t new_entry;

	logic res_free;
	logic adv_s1;
	logic is_alloc;
	logic do_alloc;
	logic do_retire;
	logic commit;
	logic prior_valid;
	logic [rbrm_pkg::PHYS_W-1:0] prior_phys;
	rbrm_pkg::map_req_t map_req;

	// Handshake between the stages.
	assign res_free  = !valid_s2 || rsp.ready;
	assign adv_s1    = valid_s1 && res_free;
	assign req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type      <= req.req_type;
			item_s1.dest_arch_reg <= req.dest_arch_reg;
			item_s1.dest_phys_reg <= req.dest_phys_reg;
			item_s1.has_dest      <= req.has_dest;
			item_s1.entry_done    <= req.entry_done;
			item_s1.is_halt       <= req.is_halt;
		end
	end

	// Request decode against the buffer state.
	assign is_alloc  = (item_s1.req_type == rbrm_pkg::REQ_ALLOC);
	assign do_alloc  = adv_s1 && is_alloc && !entry_valid_q[tail_q];
	assign do_retire = adv_s1 && !is_alloc && entry_valid_q[head_q];
	assign commit    = do_retire && head_pl_q.done && head_pl_q.has_dest
	                   && (int'(head_pl_q.arch) < ARCH_REGS)
	                   && (int'(head_pl_q.phys) < PHYS_REGS);

	assign new_entry.arch     = item_s1.dest_arch_reg;
	assign new_entry.phys     = item_s1.dest_phys_reg;
	assign new_entry.has_dest = item_s1.has_dest;
	assign new_entry.done     = item_s1.entry_done;
	assign new_entry.halt     = item_s1.is_halt;

	always_comb begin
		valid_nxt = entry_valid_q;
		head_nxt  = head_q;
		tail_nxt  = tail_q;
		if (do_alloc) begin
			valid_nxt[tail_q] = 1'b1;
			tail_nxt = (tail_q == LAST_SLOT) ? '0 : tail_q + PW'(1);
		end
		if (do_retire) begin
			valid_nxt[head_q] = 1'b0;
			head_nxt = (head_q == LAST_SLOT) ? '0 : head_q + PW'(1);
		end
	end

	assign cnt_nxt = commit_cnt_q + rbrm_pkg::COUNT_W'(do_retire && !head_pl_q.halt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			commit_cnt_q  <= '0;
		end else begin
			entry_valid_q <= valid_nxt;
			head_q        <= head_nxt;
			tail_q        <= tail_nxt;
			commit_cnt_q  <= cnt_nxt;
		end
	end

	// Entry payload memory; the entry at the next head is prefetched every cycle.
	always_ff @(posedge clk) begin
		if (do_alloc) begin
			payload_mem[tail_q] <= new_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (do_alloc && (tail_q == head_nxt)) begin
			head_pl_q <= new_entry;
		end else begin
			head_pl_q <= payload_mem[head_nxt];
		end
	end

	assign map_req.lookup = adv_s1;
	assign map_req.commit = commit;
	assign map_req.arch   = head_pl_q.arch;
	assign map_req.phys   = head_pl_q.phys;

	rbrm_retire_map #(
		.ARCH_REGS(ARCH_REGS)
	) u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (map_req),
		.prior_valid(prior_valid),
		.prior_phys (prior_phys)
	);

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2.rob_slot     <= is_alloc ? rbrm_pkg::SLOT_W'(tail_q)
			                                : rbrm_pkg::SLOT_W'(head_q);
			res_s2.accepted     <= do_alloc;
			res_s2.retired      <= do_retire;
			res_s2.freed_valid  <= commit && prior_valid;
			res_s2.commit_count <= cnt_nxt;
			res_s2.rob_full     <= valid_nxt[tail_nxt];
			res_s2.halt_retired <= do_retire && head_pl_q.halt;
		end
	end

	assign rsp.valid          = valid_s2;
	assign rsp.rob_slot       = res_s2.rob_slot;
	assign rsp.accepted       = res_s2.accepted;
	assign rsp.retired        = res_s2.retired;
	assign rsp.freed_valid    = res_s2.freed_valid;
	assign rsp.freed_phys_reg = res_s2.freed_valid ? prior_phys : '0;
	assign rsp.commit_count   = res_s2.commit_count;
	assign rsp.rob_full       = res_s2.rob_full;
	assign rsp.halt_retired   = res_s2.halt_retired;

	`RBRM_ASSERT_SAME(a_alloc_xor_retire, valid_s2, !(res_s2.accepted && res_s2.retired))
	`RBRM_ASSERT_SAME(a_freed_needs_retire, valid_s2 && res_s2.freed_valid, res_s2.retired)
	`RBRM_ASSERT_SAME(a_empty_head, !entry_valid_q[head_q], entry_valid_q == '0)
	`RBRM_ASSERT_NEXT(a_count_step, do_retire && !head_pl_q.halt, commit_cnt_q == $past(cnt_nxt))

endmodule

>>> bench/tb_reorder_buffer_with_retire_map_top.sv
// Self-checking testbench for the reorder buffer with retirement rename map.
`timescale 1ns / 1ps
module tb_reorder_buffer_with_retire_map_top;

	localparam int ROB_SLOTS   = rbrm_pkg::DEF_ROB_DEPTH;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1500;
	localparam int HOLD_AT     = 700;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_AT    = 1100;
	localparam int CALM_AT     = 1350;

	typedef struct {
		logic [rbrm_pkg::SLOT_W-1:0]  rob_slot;
		logic                         accepted;
		logic                         retired;
		logic                         freed_valid;
		logic [rbrm_pkg::PHYS_W-1:0]  freed_phys_reg;
		logic [rbrm_pkg::COUNT_W-1:0] commit_count;
		logic                         rob_full;
		logic                         halt_retired;
	} rob_response_t;

	class rob_retire_tracker;
		bit                           slot_busy[ROB_SLOTS];
		rbrm_pkg::rob_entry_t         slots[ROB_SLOTS];
		logic [rbrm_pkg::SLOT_W-1:0]  head;
		logic [rbrm_pkg::SLOT_W-1:0]  tail;
		bit                           map_valid[rbrm_pkg::DEF_ARCH_REGS];
		logic [rbrm_pkg::PHYS_W-1:0]  map_phys[rbrm_pkg::DEF_ARCH_REGS];
		logic [rbrm_pkg::COUNT_W-1:0] commits;
		rob_response_t                expected_responses[$];
		int                           errors;

		function new();
			head = '0;
			tail = '0;
			commits = '0;
			errors = 0;
		endfunction

		function logic [rbrm_pkg::SLOT_W-1:0] bump(logic [rbrm_pkg::SLOT_W-1:0] p);
			return (p == rbrm_pkg::SLOT_W'(ROB_SLOTS - 1)) ? '0 : p + 1'b1;
		endfunction

		function void note_request(rbrm_pkg::req_item_t r);
			rob_response_t        o;
			rbrm_pkg::rob_entry_t e;
			o = '{default: '0};
			if (r.req_type == rbrm_pkg::REQ_ALLOC) begin
				o.rob_slot = tail;
				if (!slot_busy[tail]) begin
					e.arch = r.dest_arch_reg;
					e.phys = r.dest_phys_reg;
					e.has_dest = r.has_dest;
					e.done = r.entry_done;
					e.halt = r.is_halt;
					slots[tail] = e;
					slot_busy[tail] = 1'b1;
					tail = bump(tail);
					o.accepted = 1'b1;
				end
			end else begin
				o.rob_slot = head;
				if (slot_busy[head]) begin
					e = slots[head];
					if (e.done && e.has_dest && int'(e.arch) < rbrm_pkg::DEF_ARCH_REGS
							&& int'(e.phys) < rbrm_pkg::DEF_PHYS_REGS) begin
						if (map_valid[e.arch]) begin
							o.freed_valid = 1'b1;
							o.freed_phys_reg = map_phys[e.arch];
						end
						map_valid[e.arch] = 1'b1;
						map_phys[e.arch] = e.phys;
					end
					if (e.halt) begin
						o.halt_retired = 1'b1;
					end else begin
						commits = commits + 1'b1;
					end
					slot_busy[head] = 1'b0;
					head = bump(head);
					o.retired = 1'b1;
				end
			end
			o.commit_count = commits;
			o.rob_full = slot_busy[tail];
			expected_responses.push_back(o);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		endtask

		task check_field(string what, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch(what, got, want);
		endtask

		task check_response(rob_response_t got);
			rob_response_t want;
			if (expected_responses.size() == 0) begin
				report_mismatch("result with nothing outstanding", 32'(got.rob_slot), '0);
			end else begin
				want = expected_responses.pop_front();
				check_field("rob_slot", 32'(got.rob_slot), 32'(want.rob_slot));
				check_field("accepted", 32'(got.accepted), 32'(want.accepted));
				check_field("retired", 32'(got.retired), 32'(want.retired));
				check_field("freed_valid", 32'(got.freed_valid), 32'(want.freed_valid));
				check_field("freed_phys_reg", 32'(got.freed_phys_reg),
					32'(want.freed_phys_reg));
				check_field("commit_count", got.commit_count, want.commit_count);
				check_field("rob_full", 32'(got.rob_full), 32'(want.rob_full));
				check_field("halt_retired", 32'(got.halt_retired), 32'(want.halt_retired));
			end
		endtask

		function int outstanding();
			return expected_responses.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	int   sent_items = 0;
	int   mix_mode = 2;
	int   mode_left = 0;
	bit   calm = 1'b0;
	bit   hold_done = 1'b0;
	int   hold_count;
	rob_retire_tracker tracker;
	rob_response_t     seen;

	rbrm_in_if  req_ch ();
	rbrm_out_if rsp_ch ();

	reorder_buffer_with_retire_map_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready) begin
			tracker.note_request({req_ch.req_type, req_ch.dest_arch_reg, req_ch.dest_phys_reg,
				req_ch.has_dest, req_ch.entry_done, req_ch.is_halt});
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen.rob_slot = rsp_ch.rob_slot;
			seen.accepted = rsp_ch.accepted;
			seen.retired = rsp_ch.retired;
			seen.freed_valid = rsp_ch.freed_valid;
			seen.freed_phys_reg = rsp_ch.freed_phys_reg;
			seen.commit_count = rsp_ch.commit_count;
			seen.rob_full = rsp_ch.rob_full;
			seen.halt_retired = rsp_ch.halt_retired;
			tracker.check_response(seen);
		end
	end

	function rbrm_pkg::req_item_t make_req(rbrm_pkg::req_type_t t, int arch, int phys,
			bit dst, bit dn, bit h);
		rbrm_pkg::req_item_t r;
		r.req_type = t;
		r.dest_arch_reg = rbrm_pkg::ARCH_W'(arch);
		r.dest_phys_reg = rbrm_pkg::PHYS_W'(phys);
		r.has_dest = dst;
		r.entry_done = dn;
		r.is_halt = h;
		return r;
	endfunction

	function rbrm_pkg::req_item_t make_random_req();
		int alloc_pct;
		if (mode_left == 0) begin
			mix_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(20, 60);
		end
		mode_left--;
		if ($urandom_range(0, 9) == 0)
			return rbrm_pkg::req_item_t'($bits(rbrm_pkg::req_item_t)'($urandom));
		alloc_pct = (mix_mode == 0) ? 80 : (mix_mode == 1) ? 20 : 50;
		return make_req(($urandom_range(0, 99) < alloc_pct) ? rbrm_pkg::REQ_ALLOC
				: rbrm_pkg::REQ_RETIRE,
			$urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 7) != 0,
			$urandom_range(0, 7) != 0, $urandom_range(0, 15) == 0);
	endfunction

	task drive_request(rbrm_pkg::req_item_t r);
		if (!calm && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.req_type;
		req_ch.dest_arch_reg <= r.dest_arch_reg;
		req_ch.dest_phys_reg <= r.dest_phys_reg;
		req_ch.has_dest <= r.has_dest;
		req_ch.entry_done <= r.entry_done;
		req_ch.is_halt <= r.is_halt;
		do @(posedge clk); while (!req_ch.ready);
		sent_items++;
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && sent_items >= HOLD_AT) begin
				hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(posedge clk);
					hold_count++;
				end
			end else if (calm || $urandom_range(0, 9) != 0) begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("tb_reorder_buffer_with_retire_map_top: errors");
		$finish;
	end

	initial begin
		tracker = new();
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = rbrm_pkg::REQ_ALLOC;
		req_ch.dest_arch_reg = '0;
		req_ch.dest_phys_reg = '0;
		req_ch.has_dest = 1'b0;
		req_ch.entry_done = 1'b0;
		req_ch.is_halt = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		drive_request(make_req(rbrm_pkg::REQ_RETIRE, 0, 0, 0, 0, 0));
		drive_request(make_req(rbrm_pkg::REQ_ALLOC, 0, 0, 1, 1, 0));
		drive_request(make_req(rbrm_pkg::REQ_ALLOC, 15, 31, 1, 1, 0));
		drive_request(make_req(rbrm_pkg::REQ_ALLOC, 0, 5, 1, 1, 0));
		drive_request(make_req(rbrm_pkg::REQ_ALLOC, 3, 7, 1, 0, 0));
		drive_request(make_req(rbrm_pkg::REQ_ALLOC, 4, 8, 0, 1, 0));
		drive_request(make_req(rbrm_pkg::REQ_ALLOC, 15, 31, 1, 1, 1));
		drive_request(make_req(rbrm_pkg::REQ_ALLOC, 0, 0, 0, 0, 0));
		for (int k = 5; k < 14; k++)
			drive_request(make_req(rbrm_pkg::REQ_ALLOC, k, 31 - k, 1, 1, 0));
		drive_request(make_req(rbrm_pkg::REQ_ALLOC, 15, 31, 1, 1, 1));
		repeat (7) drive_request(make_req(rbrm_pkg::REQ_RETIRE, 15, 31, 1, 1, 1));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == CALM_AT)
				calm = 1'b1;
			if (sent_items == DRAIN_AT) begin
				req_ch.valid <= 1'b0;
				do @(posedge clk); while (tracker.outstanding() != 0);
			end
			drive_request(make_random_req());
		end
		req_ch.valid <= 1'b0;

		do @(posedge clk); while (tracker.outstanding() != 0);
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("tb_reorder_buffer_with_retire_map_top: clean");
		else
			$display("tb_reorder_buffer_with_retire_map_top: errors");
		$finish;
	end
endmodule
